>>> rtl/sqch_pkg.sv
package sqch_pkg;

    localparam int unsigned PERIOD_LIMIT_DEFAULT = 2047;

    localparam int unsigned PERIOD_W = 11;
    localparam int unsigned TARGET_W = 13;

    // item modes
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_QUARTER = 3'd1;
    localparam logic [2:0] MODE_HALF    = 3'd2;
    localparam logic [2:0] MODE_REG     = 3'd3;
    localparam logic [2:0] MODE_ENABLE  = 3'd4;

    // channel register indexes
    localparam logic [1:0] REG_DUTY_ENV = 2'd0;
    localparam logic [1:0] REG_SWEEP    = 2'd1;
    localparam logic [1:0] REG_PER_LO   = 2'd2;
    localparam logic [1:0] REG_PER_HI   = 2'd3;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] reg_index;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [3:0] sample;
        logic       length_active;
    } out_item_t;

    // one bit per sequencer step
    localparam logic [7:0] DUTY_WAVE [4] = '{
        8'b0000_0010,
        8'b0000_0110,
        8'b0001_1110,
        8'b1111_1001
    };

    localparam logic [7:0] LENGTH_LOAD [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    // sweep target, range -1 .. 4094
    function automatic logic signed [TARGET_W-1:0] sweep_target(
        input logic [PERIOD_W-1:0] period,
        input logic [2:0]          shift,
        input logic                negate,
        input logic                first
    );
        logic [TARGET_W-1:0] cur;
        logic [TARGET_W-1:0] delta;
        logic [TARGET_W-1:0] res;
        cur   = TARGET_W'(period);
        delta = TARGET_W'(period >> shift);
        if (negate) begin
            res = cur - delta - TARGET_W'(first);
        end else begin
            res = cur + delta;
        end
        return $signed(res);
    endfunction

    function automatic logic sweep_muted(
        input logic [PERIOD_W-1:0] period,
        input logic [2:0]          shift,
        input logic                negate,
        input logic                first,
        input logic [TARGET_W-1:0] limit
    );
        logic signed [TARGET_W-1:0] t;
        t = sweep_target(period, shift, negate, first);
        return (period < PERIOD_W'(8)) || (t > $signed(limit));
    endfunction

endpackage

>>> rtl/sqch_core.sv
module sqch_core #(
    parameter int unsigned PERIOD_LIMIT = sqch_pkg::PERIOD_LIMIT_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               first_channel,
    input  logic               item_accept,
    input  sqch_pkg::in_item_t item,
    output sqch_pkg::out_item_t result
);

    localparam logic [sqch_pkg::TARGET_W-1:0] LIMIT = sqch_pkg::TARGET_W'(PERIOD_LIMIT);
    localparam logic [sqch_pkg::PERIOD_W-1:0] PERIOD_MAX = '1;

    typedef struct packed {
        logic [1:0]                  duty_select;
        logic                        halt_loop;
        logic                        vol_const;
        logic [3:0]                  env_period;
        logic                        env_start;
        logic [3:0]                  env_level;
        logic [3:0]                  env_divider;
        logic                        sweep_enable;
        logic [2:0]                  sweep_period;
        logic                        sweep_negate;
        logic [2:0]                  sweep_shift;
        logic                        sweep_reload;
        logic [2:0]                  sweep_divider;
        logic [sqch_pkg::PERIOD_W-1:0] tone_period;
        logic [11:0]                 timer_count;
        logic [2:0]                  sequence_step;
        logic [7:0]                  length_count;
        logic                        channel_enable;
    } chan_state_t;

    chan_state_t state_reg;
    chan_state_t state_next;

    logic signed [sqch_pkg::TARGET_W-1:0] cur_target;
    logic                                 cur_muted;
    logic                                 next_muted;
    logic [3:0]                           level;

    always_comb begin
        cur_target = sqch_pkg::sweep_target(state_reg.tone_period, state_reg.sweep_shift,
                                            state_reg.sweep_negate, first_channel);
        cur_muted  = sqch_pkg::sweep_muted(state_reg.tone_period, state_reg.sweep_shift,
                                           state_reg.sweep_negate, first_channel, LIMIT);
        state_next = state_reg;
        if (item_accept) begin
            unique case (item.mode)
                sqch_pkg::MODE_TICK: begin
                    if (state_reg.timer_count == '0) begin
                        state_next.timer_count   = {state_reg.tone_period, 1'b1};
                        state_next.sequence_step = state_reg.sequence_step + 3'd1;
                    end else begin
                        state_next.timer_count = state_reg.timer_count - 12'd1;
                    end
                end
                sqch_pkg::MODE_QUARTER: begin
                    if (state_reg.env_start) begin
                        state_next.env_start   = 1'b0;
                        state_next.env_level   = 4'd15;
                        state_next.env_divider = state_reg.env_period;
                    end else if (state_reg.env_divider == '0) begin
                        state_next.env_divider = state_reg.env_period;
                        if (state_reg.env_level != '0) begin
                            state_next.env_level = state_reg.env_level - 4'd1;
                        end else if (state_reg.halt_loop) begin
                            state_next.env_level = 4'd15;
                        end
                    end else begin
                        state_next.env_divider = state_reg.env_divider - 4'd1;
                    end
                end
                sqch_pkg::MODE_HALF: begin
                    if (state_reg.length_count != '0 && !state_reg.halt_loop) begin
                        state_next.length_count = state_reg.length_count - 8'd1;
                    end
                    if (state_reg.sweep_divider == '0 && state_reg.sweep_enable && !cur_muted
                            && state_reg.sweep_shift != '0) begin
                        // clamp negative to zero, saturate above the 11-bit range
                        if (cur_target < 0) begin
                            state_next.tone_period = '0;
                        end else if (cur_target > $signed({2'b00, PERIOD_MAX})) begin
                            state_next.tone_period = PERIOD_MAX;
                        end else begin
                            state_next.tone_period = cur_target[sqch_pkg::PERIOD_W-1:0];
                        end
                    end
                    if (state_reg.sweep_divider == '0 || state_reg.sweep_reload) begin
                        state_next.sweep_divider = state_reg.sweep_period;
                        state_next.sweep_reload  = 1'b0;
                    end else begin
                        state_next.sweep_divider = state_reg.sweep_divider - 3'd1;
                    end
                end
                sqch_pkg::MODE_REG: begin
                    unique case (item.reg_index)
                        sqch_pkg::REG_DUTY_ENV: begin
                            state_next.duty_select = item.data[7:6];
                            state_next.halt_loop   = item.data[5];
                            state_next.vol_const   = item.data[4];
                            state_next.env_period  = item.data[3:0];
                        end
                        sqch_pkg::REG_SWEEP: begin
                            state_next.sweep_enable = item.data[7];
                            state_next.sweep_period = item.data[6:4];
                            state_next.sweep_negate = item.data[3];
                            state_next.sweep_shift  = item.data[2:0];
                            state_next.sweep_reload = 1'b1;
                        end
                        sqch_pkg::REG_PER_LO: begin
                            state_next.tone_period = {state_reg.tone_period[10:8], item.data};
                        end
                        sqch_pkg::REG_PER_HI: begin
                            state_next.tone_period = {item.data[2:0],
                                                      state_reg.tone_period[7:0]};
                            if (state_reg.channel_enable) begin
                                state_next.length_count = sqch_pkg::LENGTH_LOAD[item.data[7:3]];
                            end
                            state_next.sequence_step = '0;
                            state_next.env_start     = 1'b1;
                        end
                    endcase
                end
                sqch_pkg::MODE_ENABLE: begin
                    state_next.channel_enable = item.data[0];
                    if (!item.data[0]) begin
                        state_next.length_count = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output level is taken from the state after the item
    always_comb begin
        next_muted = sqch_pkg::sweep_muted(state_next.tone_period, state_next.sweep_shift,
                                           state_next.sweep_negate, first_channel, LIMIT);
        level = state_next.vol_const ? state_next.env_period : state_next.env_level;
        if (!state_next.channel_enable || state_next.length_count == '0
                || !sqch_pkg::DUTY_WAVE[state_next.duty_select][state_next.sequence_step]
                || next_muted) begin
            level = '0;
        end
        result.sample        = level;
        result.length_active = (state_next.length_count != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/sqch_out_buf.sv
module sqch_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sqch_pkg::out_item_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sqch_pkg::out_item_t out_data
);

    logic                main_valid_reg;
    logic                skid_valid_reg;
    sqch_pkg::out_item_t main_reg;
    sqch_pkg::out_item_t skid_reg;
    logic                main_free;
    logic                push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end else if (push) begin
            skid_reg <= in_data;
        end
    end

endmodule

>>> rtl/square_wave_channel_sweep_envelope.sv
// the result of an accepted item is registered in the output buffer and offered from there
// throughput: one item per cycle while s_ready is high; the channel state updates in the accept cycle
// a two-entry output buffer keeps the input open while one result waits
// reset: aresetn synchronous active low, all channel state zero, first_channel set
module square_wave_channel_sweep_envelope #(
    parameter int unsigned PERIOD_LIMIT = sqch_pkg::PERIOD_LIMIT_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  sqch_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sqch_pkg::out_item_t m_data
);

    logic                first_channel_reg;
    logic                s_accept;
    sqch_pkg::out_item_t core_result;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_channel_reg <= 1'b1;
        end else if (cfg_valid) begin
            first_channel_reg <= cfg_data;
        end
    end

    sqch_core #(
        .PERIOD_LIMIT(PERIOD_LIMIT)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .first_channel(first_channel_reg),
        .item_accept  (s_accept),
        .item         (s_data),
        .result       (core_result)
    );

    sqch_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (core_result),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (m_data)
    );

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted item left no result");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    a_sound_needs_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.sample != 4'd0 |-> m_data.length_active)
        else $error("nonzero sample with length counter at zero");

    a_stall_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && m_ready |=> s_ready)
        else $error("output buffer did not drain");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sqch_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // sequencer output per duty setting, bit n is step n
    localparam logic [7:0] DUTY_BITS [4] = '{
        8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
    };

    localparam int LENGTH_TABLE [32] = '{
        10, 254, 20, 2, 40, 4, 80, 6, 160, 8, 60, 10, 14, 12, 26, 14,
        12, 16, 24, 18, 48, 20, 96, 22, 192, 24, 72, 26, 16, 28, 32, 30
    };

    class channel_scoreboard;
        bit        first_channel;
        bit [1:0]  duty_select;
        bit        halt_loop;
        bit        vol_const;
        bit [3:0]  env_period;
        bit        env_start;
        bit [3:0]  env_level;
        bit [3:0]  env_divider;
        bit        sweep_enable;
        bit [2:0]  sweep_period;
        bit        sweep_negate;
        bit [2:0]  sweep_shift;
        bit        sweep_reload;
        bit [2:0]  sweep_divider;
        bit [10:0] tone_period;
        bit [11:0] timer_count;
        bit [2:0]  sequence_step;
        bit [7:0]  length_count;
        bit        channel_enable;
        out_item_t expected_levels [$];
        int        errors;

        function new();
            first_channel = 1'b1;
            errors = 0;
        endfunction

        function int sweep_goal();
            int cur;
            int delta;
            cur = tone_period;
            delta = tone_period >> sweep_shift;
            if (sweep_negate) begin
                return first_channel ? cur - delta - 1 : cur - delta;
            end
            return cur + delta;
        endfunction

        function bit sweep_mutes();
            return tone_period < 8 || sweep_goal() > int'(PERIOD_LIMIT_DEFAULT);
        endfunction

        function void clock_envelope();
            if (env_start) begin
                env_start = 1'b0;
                env_level = 4'd15;
                env_divider = env_period;
            end else if (env_divider == 0) begin
                env_divider = env_period;
                if (env_level != 0) begin
                    env_level--;
                end else if (halt_loop) begin
                    env_level = 4'd15;
                end
            end else begin
                env_divider--;
            end
        endfunction

        function void step_half_frame();
            int goal;
            if (length_count != 0 && !halt_loop) length_count--;
            if (sweep_divider == 0 && sweep_enable && !sweep_mutes() && sweep_shift != 0) begin
                goal = sweep_goal();
                if (goal < 0) goal = 0;
                if (goal > 2047) goal = 2047;
                tone_period = 11'(goal);
            end
            if (sweep_divider == 0 || sweep_reload) begin
                sweep_divider = sweep_period;
                sweep_reload = 1'b0;
            end else begin
                sweep_divider--;
            end
        endfunction

        function void write_channel_reg(bit [1:0] idx, bit [7:0] v);
            case (idx)
                REG_DUTY_ENV: begin
                    duty_select = v[7:6];
                    halt_loop = v[5];
                    vol_const = v[4];
                    env_period = v[3:0];
                end
                REG_SWEEP: begin
                    sweep_enable = v[7];
                    sweep_period = v[6:4];
                    sweep_negate = v[3];
                    sweep_shift = v[2:0];
                    sweep_reload = 1'b1;
                end
                REG_PER_LO: begin
                    tone_period[7:0] = v;
                end
                default: begin
                    tone_period[10:8] = v[2:0];
                    if (channel_enable) length_count = 8'(LENGTH_TABLE[v[7:3]]);
                    sequence_step = 3'd0;
                    env_start = 1'b1;
                end
            endcase
        endfunction

        // advance the channel by one accepted item and queue the level it reports
        function void note_item(in_item_t it);
            out_item_t want;
            case (it.mode)
                MODE_TICK: begin
                    if (timer_count == 0) begin
                        timer_count = 12'(2 * tone_period + 1);
                        sequence_step++;
                    end else begin
                        timer_count--;
                    end
                end
                MODE_QUARTER: clock_envelope();
                MODE_HALF: step_half_frame();
                MODE_REG: write_channel_reg(it.reg_index, it.data);
                MODE_ENABLE: begin
                    channel_enable = it.data[0];
                    if (!channel_enable) length_count = 8'd0;
                end
                default: ;
            endcase
            want.sample = vol_const ? env_period : env_level;
            if (!channel_enable || length_count == 0 ||
                !DUTY_BITS[duty_select][sequence_step] || sweep_mutes()) begin
                want.sample = 4'd0;
            end
            want.length_active = length_count != 0;
            expected_levels.insert(expected_levels.size(), want);
        endfunction

        function void check_level(out_item_t got);
            out_item_t want;
            if (expected_levels.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual sample %0d active %0b",
                         $time, got.sample, got.length_active);
                return;
            end
            want = expected_levels.pop_front();
            if (got.sample !== want.sample) begin
                errors++;
                $display("%0t: sample mismatch, expected %0d actual %0d",
                         $time, want.sample, got.sample);
            end
            if (got.length_active !== want.length_active) begin
                errors++;
                $display("%0t: length_active mismatch, expected %0b actual %0b",
                         $time, want.length_active, got.length_active);
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b1;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    channel_scoreboard sb = new();
    int cycle_count = 0;
    int items_sent = 0;
    int stall_left = 0;
    bit allow_gaps = 1'b1;
    bit gaps_on = 1'b1;

    square_wave_channel_sweep_envelope DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check, then decide backpressure for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) sb.check_level(m_data);
        if (stall_left > 0) begin
            stall_left--;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4);
        end
        m_ready <= (stall_left == 0);
    end

    task automatic send(input logic [2:0] mode, input logic [1:0] idx, input logic [7:0] data);
        in_item_t it;
        it.mode = mode;
        it.reg_index = idx;
        it.data = data;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic configure_negate(input bit first);
        s_valid <= 1'b0;
        while (sb.expected_levels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= first;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.first_channel = first;
        cfg_valid <= 1'b0;
    endtask

    // length index random, period high bits mostly zero so the sequencer keeps moving
    function automatic logic [7:0] period_high_byte();
        return {5'($urandom), ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0};
    endfunction

    function automatic logic [7:0] period_low_byte();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
    endfunction

    task automatic play_program();
        int n;
        int r;
        logic [1:0] idx;
        gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 7) == 0) begin
            // noise: any mode, any fields
            n = $urandom_range(3, 12);
            repeat (n) send(3'($urandom), 2'($urandom), 8'($urandom));
            return;
        end
        send(MODE_ENABLE, 2'($urandom), {7'($urandom), 1'($urandom_range(0, 7) != 0)});
        send(MODE_REG, REG_DUTY_ENV, 8'($urandom));
        send(MODE_REG, REG_SWEEP, 8'($urandom));
        send(MODE_REG, REG_PER_LO, period_low_byte());
        send(MODE_REG, REG_PER_HI, period_high_byte());
        n = $urandom_range(20, 80);
        repeat (n) begin
            r = $urandom_range(0, 99);
            idx = 2'($urandom);
            if (r < 70) begin
                send(MODE_TICK, 2'($urandom), 8'($urandom));
            end else if (r < 80) begin
                send(MODE_QUARTER, 2'($urandom), 8'($urandom));
            end else if (r < 90) begin
                send(MODE_HALF, 2'($urandom), 8'($urandom));
            end else if (r < 96) begin
                send(MODE_REG, idx, (idx == REG_PER_HI) ? period_high_byte() :
                     (idx == REG_PER_LO) ? period_low_byte() : 8'($urandom));
            end else begin
                send(3'($urandom_range(4, 7)), 2'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) play_program();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure_negate(1'b1);

        // unused modes change nothing
        send(3'd5, 2'd3, 8'hFF);
        send(3'd6, 2'd0, 8'h00);
        send(3'd7, 2'd1, 8'hAA);
        // period high write while disabled must not load the length counter
        send(MODE_REG, REG_PER_HI, 8'hFF);
        send(MODE_ENABLE, 2'd0, 8'h01);
        send(MODE_REG, REG_DUTY_ENV, 8'hBF);
        send(MODE_REG, REG_SWEEP, 8'h00);
        // period under 8 mutes
        send(MODE_REG, REG_PER_LO, 8'h03);
        send(MODE_REG, REG_PER_HI, 8'h08);
        repeat (3) send(MODE_TICK, 2'd0, 8'h00);
        // period 255 with an enabled negate sweep at shift 7 lowers the period on a half frame
        send(MODE_REG, REG_PER_LO, 8'hFF);
        send(MODE_REG, REG_PER_HI, 8'hF8);
        send(MODE_REG, REG_SWEEP, 8'hFF);
        send(MODE_HALF, 2'd3, 8'hFF);
        send(MODE_QUARTER, 2'd0, 8'h00);
        send(MODE_QUARTER, 2'd0, 8'h00);
        send(MODE_HALF, 2'd0, 8'h00);
        // disable clears the length counter, only bit 0 counts
        send(MODE_ENABLE, 2'd0, 8'h00);
        send(MODE_ENABLE, 2'd2, 8'hFE);

        configure_negate(1'b0);
        run_random(700);
        configure_negate(1'b1);
        run_random(700);
        configure_negate(1'b0);
        allow_gaps = 1'b0;
        gaps_on = 1'b0;
        run_random(600);

        s_valid <= 1'b0;
        while (sb.expected_levels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sqch_pkg.sv
rtl/sqch_core.sv
rtl/sqch_out_buf.sv
rtl/square_wave_channel_sweep_envelope.sv
sim/testbench.sv
